### rtl/core/udp_hdr_pkg.sv
// ============================================================================
// udp_hdr_pkg
// Shared widths, field constants, register indexes and word positions for the
// Ethernet/IPv4/UDP header generator.
// ============================================================================
package udp_hdr_pkg;

    localparam int LEN_W      = 16;
    localparam int WORD_W     = 16;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;

    // Checksum partial sums
    localparam int CFG_SUM_W  = 19;
    localparam int SUM_W      = 20;
    localparam int FOLD_W     = 17;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_SOURCE_MAC  = 3'd0;
    localparam cfg_idx_t REG_SOURCE_IP   = 3'd1;
    localparam cfg_idx_t REG_DEST_IP     = 3'd2;
    localparam cfg_idx_t REG_SOURCE_PORT = 3'd3;
    localparam cfg_idx_t REG_DEST_PORT   = 3'd4;

    // Fixed header fields
    localparam word_t BCAST_WORD     = 16'hFFFF;
    localparam word_t ETHERTYPE_IPV4 = 16'h0800;
    localparam word_t IP_VER_IHL_TOS = 16'h4500;
    localparam word_t IP_IDENT       = 16'hA004;
    localparam word_t IP_FLAGS_FRAG  = 16'h0000;
    localparam word_t IP_TTL_PROTO   = 16'h4011;
    localparam word_t UDP_CSUM       = 16'h0000;
    localparam len_t  IP_UDP_HDR_LEN = 16'd28;
    localparam len_t  UDP_HDR_LEN    = 16'd8;

    // Word positions within the header
    localparam idx_t WI_DST_MAC0   = 5'd0;
    localparam idx_t WI_DST_MAC1   = 5'd1;
    localparam idx_t WI_DST_MAC2   = 5'd2;
    localparam idx_t WI_SRC_MAC0   = 5'd3;
    localparam idx_t WI_SRC_MAC1   = 5'd4;
    localparam idx_t WI_SRC_MAC2   = 5'd5;
    localparam idx_t WI_ETHERTYPE  = 5'd6;
    localparam idx_t WI_VER_IHL    = 5'd7;
    localparam idx_t WI_TOTAL_LEN  = 5'd8;
    localparam idx_t WI_IDENT      = 5'd9;
    localparam idx_t WI_FLAGS      = 5'd10;
    localparam idx_t WI_TTL_PROTO  = 5'd11;
    localparam idx_t WI_IP_CSUM    = 5'd12;
    localparam idx_t WI_SRC_IP0    = 5'd13;
    localparam idx_t WI_SRC_IP1    = 5'd14;
    localparam idx_t WI_DST_IP0    = 5'd15;
    localparam idx_t WI_DST_IP1    = 5'd16;
    localparam idx_t WI_SRC_PORT   = 5'd17;
    localparam idx_t WI_DST_PORT   = 5'd18;
    localparam idx_t WI_UDP_LEN    = 5'd19;
    localparam idx_t WI_UDP_CSUM   = 5'd20;
    localparam idx_t WI_LAST       = WI_UDP_CSUM;

    // Put the first wire byte in the low byte
    function automatic word_t swap16(input word_t w);
        return {w[7:0], w[15:8]};
    endfunction

endpackage

### rtl/core/udp_hdr_if.sv
// ============================================================================
// udp_hdr_len_if / udp_hdr_word_if
// Valid/ready channels: payload length requests in, header words out.
// ============================================================================
interface udp_hdr_len_if
    import udp_hdr_pkg::*;
();
    logic valid;
    logic ready;
    len_t payload_length;

    modport source (output valid, output payload_length, input ready);
    modport sink   (input valid, input payload_length, output ready);
endinterface

interface udp_hdr_word_if
    import udp_hdr_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t header_word;
    idx_t  word_index;
    logic  last_word;

    modport source (output valid, output header_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input header_word, input word_index, input last_word,
                    output ready);
endinterface

### rtl/core/udp_ipv4_header_generator.sv
// ============================================================================
// udp_ipv4_header_generator
// Emits the 21-word broadcast Ethernet/IPv4/UDP header for each payload length.
// ============================================================================
// Flow: a taken request is held in the word sequencer, and each header word
//   passes through the output register. Throughput: one header word per cycle
//   while the receiver holds ready; the next request is taken as the last word leaves.
// Reset: rst_n (async, active low) clears the address/port registers to zero
//   and empties the word sequencer and output register.
module udp_ipv4_header_generator
    import udp_hdr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    udp_hdr_len_if.sink           length,
    udp_hdr_word_if.source        header
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAC_W-1:0]  source_mac_reg;
    logic [IP_W-1:0]   source_ip_reg;
    logic [IP_W-1:0]   dest_ip_reg;
    logic [PORT_W-1:0] source_port_reg;
    logic [PORT_W-1:0] dest_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg  <= '0;
            source_ip_reg   <= '0;
            dest_ip_reg     <= '0;
            source_port_reg <= '0;
            dest_port_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_MAC:  source_mac_reg  <= cfg_data[MAC_W-1:0];
                REG_SOURCE_IP:   source_ip_reg   <= cfg_data[IP_W-1:0];
                REG_DEST_IP:     dest_ip_reg     <= cfg_data[IP_W-1:0];
                REG_SOURCE_PORT: source_port_reg <= cfg_data[PORT_W-1:0];
                REG_DEST_PORT:   dest_port_reg   <= cfg_data[PORT_W-1:0];
                default:         ; // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Static part of the IP checksum: fixed fields plus the four address
    // words. Registered; config is to change only while idle (not enforced
    // here), so it has settled long before any request reaches the checksum word.
    // ------------------------------------------------------------------
    logic [CFG_SUM_W-1:0] cfg_sum_reg;
    logic [CFG_SUM_W-1:0] cfg_sum_next;

    always_comb
    begin
        cfg_sum_next = CFG_SUM_W'(IP_VER_IHL_TOS) + CFG_SUM_W'(IP_IDENT)
                     + CFG_SUM_W'(IP_FLAGS_FRAG)  + CFG_SUM_W'(IP_TTL_PROTO)
                     + CFG_SUM_W'(source_ip_reg[31:16]) + CFG_SUM_W'(source_ip_reg[15:0])
                     + CFG_SUM_W'(dest_ip_reg[31:16])   + CFG_SUM_W'(dest_ip_reg[15:0]);
    end

    always_ff @(posedge clk)
    begin
        cfg_sum_reg <= cfg_sum_next;
    end

    // ------------------------------------------------------------------
    // Word sequencer: holds the current request and walks positions 0..20
    // ------------------------------------------------------------------
    logic  busy_reg;
    logic  busy_next;
    idx_t  idx_reg;
    idx_t  idx_next;
    len_t  len_reg;
    len_t  len_next;
    logic  advance;
    logic  take;

    // Output register
    logic  out_valid_reg;
    logic  out_valid_next;
    word_t out_word_reg;
    idx_t  out_idx_reg;
    logic  out_last_reg;

    // Move a word into the output register when it is empty or being drained
    assign advance = busy_reg && (!out_valid_reg || header.ready);

    // Take the next request while idle or while the last word leaves
    assign length.ready = !busy_reg || (advance && (idx_reg == WI_LAST));
    assign take         = length.valid && length.ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        len_next  = len_reg;
        if (take)
        begin
            busy_next = 1'b1;
            idx_next  = WI_DST_MAC0;
            len_next  = length.payload_length;
        end
        else if (advance)
        begin
            if (idx_reg == WI_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= WI_DST_MAC0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    // ------------------------------------------------------------------
    // Length fields and IP checksum. sum_reg and then fold_reg follow the
    // held length, well before the checksum word at position 12 is due.
    // ------------------------------------------------------------------
    len_t              total_len;
    len_t              udp_len;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [FOLD_W-1:0] fold_reg;
    logic [FOLD_W-1:0] fold_next;
    word_t             ip_csum;

    assign total_len = len_reg + IP_UDP_HDR_LEN;
    assign udp_len   = len_reg + UDP_HDR_LEN;

    assign sum_next  = SUM_W'(cfg_sum_reg) + SUM_W'(total_len);
    assign fold_next = FOLD_W'(sum_reg[15:0]) + FOLD_W'(sum_reg[SUM_W-1:16]);

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        fold_reg <= fold_next;
    end

    // Second end-around fold cannot carry again, then complement
    assign ip_csum = ~(fold_reg[15:0] + WORD_W'(fold_reg[16]));

    // ------------------------------------------------------------------
    // Header word select
    // ------------------------------------------------------------------
    word_t hdr_word;

    always_comb
    begin
        case (idx_reg)
            WI_DST_MAC0, WI_DST_MAC1, WI_DST_MAC2:
                hdr_word = BCAST_WORD;
            WI_SRC_MAC0:  hdr_word = source_mac_reg[47:32];
            WI_SRC_MAC1:  hdr_word = source_mac_reg[31:16];
            WI_SRC_MAC2:  hdr_word = source_mac_reg[15:0];
            WI_ETHERTYPE: hdr_word = ETHERTYPE_IPV4;
            WI_VER_IHL:   hdr_word = IP_VER_IHL_TOS;
            WI_TOTAL_LEN: hdr_word = total_len;
            WI_IDENT:     hdr_word = IP_IDENT;
            WI_FLAGS:     hdr_word = IP_FLAGS_FRAG;
            WI_TTL_PROTO: hdr_word = IP_TTL_PROTO;
            WI_IP_CSUM:   hdr_word = ip_csum;
            WI_SRC_IP0:   hdr_word = source_ip_reg[31:16];
            WI_SRC_IP1:   hdr_word = source_ip_reg[15:0];
            WI_DST_IP0:   hdr_word = dest_ip_reg[31:16];
            WI_DST_IP1:   hdr_word = dest_ip_reg[15:0];
            WI_SRC_PORT:  hdr_word = source_port_reg;
            WI_DST_PORT:  hdr_word = dest_port_reg;
            WI_UDP_LEN:   hdr_word = udp_len;
            WI_UDP_CSUM:  hdr_word = UDP_CSUM;
            default:      hdr_word = UDP_CSUM;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: hold until taken, load the next word on advance
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (header.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= swap16(hdr_word);
            out_idx_reg  <= idx_reg;
            out_last_reg <= (idx_reg == WI_LAST);
        end
    end

    assign header.valid       = out_valid_reg;
    assign header.header_word = out_word_reg;
    assign header.word_index  = out_idx_reg;
    assign header.last_word   = out_last_reg;

endmodule

### tb/sv/tb_udp_ipv4_header_generator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_udp_ipv4_header_generator
// Self-checking bench for the Ethernet/IPv4/UDP header generator. Payload
// length requests go in with random sender gaps. Header words come out under
// random receiver stalls. Each word is checked against a predicted 21-word
// header built from a mirrored copy of the address and port registers.
// ============================================================================
import udp_hdr_pkg::*;

typedef struct packed {
    word_t header_word;
    idx_t  word_index;
    logic  last_word;
} hdr_word_t;

class header_scoreboard;
    hdr_word_t       pending_words[$];
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  src_ip;
    logic [IP_W-1:0]  dst_ip;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    int unsigned     error_count;
    int unsigned     request_count;
    int unsigned     word_count;

    function new();
        mac = '0;
        src_ip = '0;
        dst_ip = '0;
        src_port = '0;
        dst_port = '0;
        error_count = 0;
        request_count = 0;
        word_count = 0;
    endfunction

    // Mirror a register write; out-of-range indexes are dropped, wide data is cut
    function void set_register(cfg_idx_t index, logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_SOURCE_MAC:  mac = data[MAC_W-1:0];
            REG_SOURCE_IP:   src_ip = data[IP_W-1:0];
            REG_DEST_IP:     dst_ip = data[IP_W-1:0];
            REG_SOURCE_PORT: src_port = data[PORT_W-1:0];
            REG_DEST_PORT:   dst_port = data[PORT_W-1:0];
            default: ;
        endcase
    endfunction

    // Build the full header for one accepted request and queue its words
    function void note_request(len_t plen);
        word_t       hdr [WI_LAST+1];
        logic [31:0] ip_sum;
        hdr_word_t   item;
        int          k;

        hdr[WI_DST_MAC0]  = BCAST_WORD;
        hdr[WI_DST_MAC1]  = BCAST_WORD;
        hdr[WI_DST_MAC2]  = BCAST_WORD;
        hdr[WI_SRC_MAC0]  = mac[47:32];
        hdr[WI_SRC_MAC1]  = mac[31:16];
        hdr[WI_SRC_MAC2]  = mac[15:0];
        hdr[WI_ETHERTYPE] = ETHERTYPE_IPV4;
        hdr[WI_VER_IHL]   = IP_VER_IHL_TOS;
        hdr[WI_TOTAL_LEN] = word_t'(plen + IP_UDP_HDR_LEN);
        hdr[WI_IDENT]     = IP_IDENT;
        hdr[WI_FLAGS]     = IP_FLAGS_FRAG;
        hdr[WI_TTL_PROTO] = IP_TTL_PROTO;
        hdr[WI_IP_CSUM]   = '0;
        hdr[WI_SRC_IP0]   = src_ip[31:16];
        hdr[WI_SRC_IP1]   = src_ip[15:0];
        hdr[WI_DST_IP0]   = dst_ip[31:16];
        hdr[WI_DST_IP1]   = dst_ip[15:0];
        hdr[WI_SRC_PORT]  = src_port;
        hdr[WI_DST_PORT]  = dst_port;
        hdr[WI_UDP_LEN]   = word_t'(plen + UDP_HDR_LEN);
        hdr[WI_UDP_CSUM]  = UDP_CSUM;

        ip_sum = '0;
        for (k = WI_VER_IHL; k <= WI_DST_IP1; k++)
            ip_sum += 32'(hdr[k]);
        while (ip_sum[31:16] != 16'd0)
            ip_sum = {16'd0, ip_sum[15:0]} + {16'd0, ip_sum[31:16]};
        hdr[WI_IP_CSUM] = ~ip_sum[15:0];

        for (k = 0; k <= WI_LAST; k++) begin
            item.header_word = {<<8{hdr[k]}};
            item.word_index  = idx_t'(k);
            item.last_word   = (k == WI_LAST);
            pending_words.push_back(item);
        end
        request_count++;
    endfunction

    function void check_word(word_t hword, idx_t index, logic last);
        hdr_word_t want;

        word_count++;
        if (pending_words.size() == 0) begin
            $error("unexpected header word %h at index %0d", hword, index);
            error_count++;
            return;
        end
        want = pending_words.pop_front();
        if (hword !== want.header_word) begin
            $error("header_word mismatch: expected %h, actual %h", want.header_word, hword);
            error_count++;
        end
        if (index !== want.word_index) begin
            $error("word_index mismatch: expected %0d, actual %0d", want.word_index, index);
            error_count++;
        end
        if (last !== want.last_word) begin
            $error("last_word mismatch: expected %0b, actual %0b", want.last_word, last);
            error_count++;
        end
    endfunction

    function int pending();
        return pending_words.size();
    endfunction
endclass

module tb_udp_ipv4_header_generator;

    localparam int       RANDOM_PHASES    = 8;
    localparam int       PHASE_REQUESTS   = 45;
    localparam int       SETTLE_CYCLES    = 6;
    localparam int       DRAIN_CYCLES     = 20;
    localparam int       WATCHDOG_LIMIT   = 2000;
    localparam len_t     MAX_PAYLOAD      = 16'd65507;
    localparam cfg_idx_t REG_UNUSED_FIRST = REG_DEST_PORT + 1;
    localparam cfg_idx_t REG_INDEX_TOP    = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // When clear, both sides run flat out
    logic                  idle_on;
    int                    stall_left;
    int                    watchdog_count;
    int                    setting_count;

    header_scoreboard      sb;

    udp_hdr_len_if  len_ch ();
    udp_hdr_word_if hdr_ch ();

    udp_ipv4_header_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .length    (len_ch),
        .header    (hdr_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Receiver: check each accepted header word, then pick next cycle's ready.
    // Stalls come in random bursts while idling is enabled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n) begin
            hdr_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (hdr_ch.valid && hdr_ch.ready)
                sb.check_word(hdr_ch.header_word, hdr_ch.word_index, hdr_ch.last_word);
            if (stall_left > 0) begin
                hdr_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hdr_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                hdr_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either channel for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((len_ch.valid && len_ch.ready) || (hdr_ch.valid && hdr_ch.ready))
                watchdog_count = 0;
            else
                watchdog_count++;
            if (watchdog_count >= WATCHDOG_LIMIT) begin
                $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Send one length request; optionally hold valid low for a short gap first
    task automatic send_length(input len_t plen);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            len_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        len_ch.valid          <= 1'b1;
        len_ch.payload_length <= plen;
        do
            @(posedge clk);
        while (!(len_ch.valid && len_ch.ready));
        sb.note_request(plen);
    endtask

    // Lower valid after the last request of a batch
    task automatic end_batch();
        len_ch.valid <= 1'b0;
    endtask

    // Wait until every predicted word has come out, then let the pipe settle
    task automatic await_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller lowers cfg_write after its last write
    task automatic write_register(input cfg_idx_t index, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(index, data);
    endtask

    task automatic program_all(input logic [CFG_DATA_W-1:0] mac_val,
                               input logic [CFG_DATA_W-1:0] sip_val,
                               input logic [CFG_DATA_W-1:0] dip_val,
                               input logic [CFG_DATA_W-1:0] sport_val,
                               input logic [CFG_DATA_W-1:0] dport_val);
        write_register(REG_SOURCE_MAC, mac_val);
        write_register(REG_SOURCE_IP, sip_val);
        write_register(REG_DEST_IP, dip_val);
        write_register(REG_SOURCE_PORT, sport_val);
        write_register(REG_DEST_PORT, dport_val);
        // A write past the register list must leave everything untouched
        write_register(cfg_idx_t'($urandom_range(REG_UNUSED_FIRST, REG_INDEX_TOP)),
                       CFG_DATA_W'({$urandom(), $urandom()}));
        cfg_write <= 1'b0;
        setting_count++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_data();
        return CFG_DATA_W'({$urandom(), $urandom()});
    endfunction

    // Mostly legal lengths, with short ones, near-max ones and over-range ones
    function automatic len_t rand_length();
        case ($urandom_range(0, 9))
            0:       return len_t'($urandom_range(0, 15));
            1:       return len_t'($urandom());
            2:       return len_t'($urandom_range(65500, 65535));
            default: return len_t'($urandom_range(0, MAX_PAYLOAD));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        len_t directed_reset [] = '{16'd0, 16'd1, MAX_PAYLOAD, 16'd65508, 16'd65527,
                                    16'd65528, 16'hFFFF, 16'hAAAA, 16'h5555, 16'd1472};
        len_t directed_ones  [] = '{16'd0, MAX_PAYLOAD, 16'hFFFF, 16'd65508,
                                    16'h8000, 16'h7FFF, 16'd20};
        int   p;
        int   n;
        int   mode;

        sb                    = new();
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = REG_SOURCE_MAC;
        cfg_data              = '0;
        len_ch.valid          = 1'b0;
        len_ch.payload_length = '0;
        hdr_ch.ready          = 1'b0;
        idle_on               = 1'b1;
        stall_left            = 0;
        watchdog_count        = 0;
        setting_count         = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: all registers zero. Hit length extremes and both wraps
        // (total length wraps to zero at 65508, UDP length at 65528).
        foreach (directed_reset[i])
            send_length(directed_reset[i]);
        end_batch();
        await_idle();

        // All-ones registers, fed through full-width data so the upper bits
        // must be dropped; this also forces several end-around carry folds.
        program_all('1, '1, '1, '1, '1);
        foreach (directed_ones[i])
            send_length(directed_ones[i]);
        end_batch();
        await_idle();

        // Alternating bit patterns across every register
        program_all(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        send_length(16'h5555);
        send_length(16'hAAAA);
        end_batch();
        await_idle();

        // Random phases: fresh register setting each phase, idling turned off
        // in the final phase so the block runs back to back.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
            mode = $urandom_range(0, 5);
            case (mode)
                0:       program_all('0, '0, '0, '0, '0);
                1:       program_all('1, '1, '1, '1, '1);
                default: program_all(rand_data(), rand_data(), rand_data(),
                                     rand_data(), rand_data());
            endcase
            for (n = 0; n < PHASE_REQUESTS; n++)
                send_length(rand_length());
            end_batch();
            await_idle();
        end

        // Anything that shows up now is an extra word
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d length requests over %0d register settings",
                 sb.request_count, setting_count + 1);
        $display("checked %0d header words, %0d mismatches",
                 sb.word_count, sb.error_count);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/core/udp_hdr_pkg.sv
rtl/core/udp_hdr_if.sv
rtl/core/udp_ipv4_header_generator.sv
tb/sv/tb_udp_ipv4_header_generator.sv
